/* hw/rtl/nhse_pkg.sv */
// Shared types, constants and fixed-point helpers for the neo-Hookean stress and energy unit.
`default_nettype none

package nhse_pkg;

	localparam int DIM_DEFAULT = 3;
	localparam int FX_ONE      = 65536;
	localparam int FX_HALF     = 32768;
	localparam int LOG_BITS    = 24;
	localparam int DIV_QBITS   = 48;
	// Pipelined divider: operand prep, one quotient bit per stage, final clip.
	localparam int DIV_LAT     = DIV_QBITS + 2;
	// Log unit: leading-one search, normalize, squaring steps, scale, round.
	localparam int LN_LAT      = LOG_BITS + 4;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] FX_MIN = 32'sh80000000;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONPOS = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	localparam logic [1:0] CFG_SHEAR = 2'd0;
	localparam logic [1:0] CFG_LAME  = 2'd1;

	// Unique entries of a symmetric 3x3 matrix: 11 22 33 12 13 23.
	localparam int SYM_I [6] = '{0, 1, 2, 0, 0, 1};
	localparam int SYM_J [6] = '{0, 1, 2, 1, 2, 2};
	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

	typedef struct packed {
		logic signed [31:0] v;
		logic               sat;
	} fx_t;

	function automatic fx_t fx_clip(input logic signed [63:0] x);
		fx_t r;
		if (x > 64'sd2147483647) begin
			r.v = FX_MAX;
			r.sat = 1'b1;
		end else if (x < -64'sd2147483648) begin
			r.v = FX_MIN;
			r.sat = 1'b1;
		end else begin
			r.v = x[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic fx_t fx_mul(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + 64'sd32768;
		return fx_clip(p >>> 16);
	endfunction

	function automatic fx_t fx_add(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] s;
		s = a + b;
		return fx_clip(s);
	endfunction

	function automatic fx_t fx_sub(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] s;
		s = a - b;
		return fx_clip(s);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/neohookean_stress_and_energy_unit.sv */
// Top level of the compressible neo-Hookean stress and energy pipeline.
// Usage:
// Each request on the slave stream carries the nine displacement-gradient
// entries of one quadrature point in Q16.16. The master stream returns the
// six unique stress entries and the energy density in tdata and a status
// code in tuser (0 ok, 1 determinant not positive, 2 some value saturated).
// Shear modulus and first Lame parameter are written through the plain
// write port, which the user must do only while no request is in flight;
// the block itself does not enforce this. Both reset to 1.0. A new request
// is taken every cycle while the master side is not stalled. The rounding
// divider that forms the inverse of C sets the pipeline's length, one
// quotient bit per stage over 48 stages, the logarithm unit running beside it.
// Reset clears all valid bits and restores the material registers.
// When the receiver holds tready low with a result waiting, the whole
// pipeline holds and the slave side deasserts tready; nothing is dropped
// or repeated and accepting resumes as soon as the result is taken.
`default_nettype none

module neohookean_stress_and_energy_unit import nhse_pkg::*; #(
	parameter int DIM = DIM_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// g11 g12 g13 g21 g22 g23 g31 g32 g33, 32 bits each, from bit 0 up
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// s11 s22 s33 s12 s13 s23 energy, 32 bits each, from bit 0 up
	output logic [223:0]      m_tdata,
	// status
	output logic [1:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [30:0]  cfg_data
);

	localparam int S_LN_IN  = 5;
	localparam int S_DIV_IN = 6;
	localparam int S_LNJ    = S_LN_IN + LN_LAT;
	localparam int S_E      = S_LNJ + 4;
	localparam int S_CI     = S_DIV_IN + DIV_LAT;
	localparam int S_OUT    = S_CI + 2;
	localparam int EH_LEN   = S_LNJ - 7 + 1;
	localparam int TAG_LEN  = S_CI - 7 + 1;
	localparam int CE_LEN   = S_CI - S_E + 1;
	localparam logic signed [31:0] DIM_FX = 32'(DIM * FX_ONE);

	typedef struct packed {
		logic jpos;
		logic sat;
	} tag_t;

	typedef struct packed {
		logic signed [31:0] coef;
		logic signed [31:0] energy;
		logic               sat;
	} ce_t;

	logic [30:0]        mu_q, lam_q;
	logic signed [31:0] mu, lam;
	logic [S_OUT:1]     vld_q;
	logic               adv;

	logic signed [31:0] f_s1 [3][3];
	logic               sat_s1;
	logic signed [31:0] pc_s2 [6][3];
	logic signed [31:0] pf_s2 [3][2];
	logic signed [31:0] f0_s2 [3];
	logic               sat_s2;
	logic signed [31:0] c_s3 [6];
	logic signed [31:0] cf_s3 [3];
	logic signed [31:0] f0_s3 [3];
	logic               sat_s3;
	logic signed [31:0] pj_s4 [3];
	logic signed [31:0] pcc_s4 [6][2];
	logic signed [31:0] tr_s4;
	logic               sat_s4;
	logic signed [31:0] j_s5;
	logic signed [31:0] cc_s5 [6];
	logic signed [31:0] tr_s5;
	logic               sat_s5;
	logic signed [31:0] detc_s6;
	logic signed [31:0] etr_s6;
	logic signed [31:0] cc_s6 [6];
	logic               jpos_s6;
	logic               sat_s6;

	logic signed [31:0] eh_dly_q [EH_LEN];
	tag_t               tag_dly_q [TAG_LEN];
	logic signed [31:0] lnj;
	fx_t                ci [6];

	logic signed [31:0] mlam_s34, lsq_s34, d2_s34;
	logic               sat_s34;
	logic signed [31:0] coef_s35, e1a_s35, e2_s35;
	logic               sat_s35;
	logic signed [31:0] coef_s36, e1_s36, e2_s36;
	logic               sat_s36;
	ce_t                ce_dly_q [CE_LEN];

	logic signed [31:0] ps_s57 [6];
	logic signed [31:0] en_s57;
	logic               jpos_s57;
	logic               sat_s57;
	logic signed [31:0] out_s58 [7];
	logic [1:0]         st_s58;

	// Combinational next values, one group per stage.
	logic signed [31:0] f_nx [3][3];
	logic               sat1_nx;
	logic signed [31:0] pc_nx [6][3];
	logic signed [31:0] pf_nx [3][2];
	logic               sat2_nx;
	logic signed [31:0] c_nx [6];
	logic signed [31:0] cf_nx [3];
	logic               sat3_nx;
	logic signed [31:0] pj_nx [3];
	logic signed [31:0] pcc_nx [6][2];
	logic signed [31:0] tr_nx;
	logic               sat4_nx;
	logic signed [31:0] j_nx;
	logic signed [31:0] cc_nx [6];
	logic               sat5_nx;
	fx_t                detc_nx, etr_nx, eh_nx;
	fx_t                mlam_nx, lsq_nx, d2_nx;
	fx_t                coef_nx, e1a_nx, e2_nx, e1_nx, en_nx;
	logic signed [31:0] ps_nx [6];
	logic               sat57_nx;
	logic signed [31:0] out_nx [7];
	logic [1:0]         st_nx;

	assign mu  = {1'b0, mu_q};
	assign lam = {1'b0, lam_q};
	assign adv = !vld_q[S_OUT] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q  <= 31'(FX_ONE);
			lam_q <= 31'(FX_ONE);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHEAR: mu_q <= cfg_data;
				CFG_LAME:  lam_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[S_OUT-1:1], s_tvalid};
		end
	end

	// Stage 1: F = I + G inside DIM, identity outside.
	always_comb begin
		fx_t                r;
		logic signed [31:0] d;
		sat1_nx = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				d = (i == j) ? 32'(FX_ONE) : 32'sd0;
				if (i < DIM && j < DIM) begin
					r = fx_add(d, s_tdata[(i*3+j)*32 +: 32]);
					f_nx[i][j] = r.v;
					sat1_nx = sat1_nx | r.sat;
				end else begin
					f_nx[i][j] = d;
				end
			end
		end
	end

	// Stage 2: products for C and for the first-row cofactors of F.
	always_comb begin
		fx_t r;
		sat2_nx = sat_s1;
		for (int k = 0; k < 6; k++) begin
			for (int n = 0; n < 3; n++) begin
				r = fx_mul(f_s1[n][SYM_I[k]], f_s1[n][SYM_J[k]]);
				pc_nx[k][n] = r.v;
				sat2_nx = sat2_nx | r.sat;
			end
		end
		for (int j = 0; j < 3; j++) begin
			r = fx_mul(f_s1[1][NXT1[j]], f_s1[2][NXT2[j]]);
			pf_nx[j][0] = r.v;
			sat2_nx = sat2_nx | r.sat;
			r = fx_mul(f_s1[1][NXT2[j]], f_s1[2][NXT1[j]]);
			pf_nx[j][1] = r.v;
			sat2_nx = sat2_nx | r.sat;
		end
	end

	// Stage 3: C entries and cofactors.
	always_comb begin
		fx_t r;
		sat3_nx = sat_s2;
		for (int k = 0; k < 6; k++) begin
			r = fx_add(pc_s2[k][0], pc_s2[k][1]);
			sat3_nx = sat3_nx | r.sat;
			r = fx_add(r.v, pc_s2[k][2]);
			sat3_nx = sat3_nx | r.sat;
			c_nx[k] = r.v;
		end
		for (int j = 0; j < 3; j++) begin
			r = fx_sub(pf_s2[j][0], pf_s2[j][1]);
			cf_nx[j] = r.v;
			sat3_nx = sat3_nx | r.sat;
		end
	end

	// Stage 4: determinant products, cofactor products of C, trace of C.
	always_comb begin
		fx_t                r;
		logic signed [31:0] cm [3][3];
		int                 a, b;
		sat4_nx = sat_s3;
		for (int k = 0; k < 6; k++) begin
			cm[SYM_I[k]][SYM_J[k]] = c_s3[k];
			cm[SYM_J[k]][SYM_I[k]] = c_s3[k];
		end
		for (int j = 0; j < 3; j++) begin
			r = fx_mul(f0_s3[j], cf_s3[j]);
			pj_nx[j] = r.v;
			sat4_nx = sat4_nx | r.sat;
		end
		// C is symmetric, so its cofactor matrix is too and six entries suffice.
		for (int k = 0; k < 6; k++) begin
			a = SYM_I[k];
			b = SYM_J[k];
			r = fx_mul(cm[NXT1[a]][NXT1[b]], cm[NXT2[a]][NXT2[b]]);
			pcc_nx[k][0] = r.v;
			sat4_nx = sat4_nx | r.sat;
			r = fx_mul(cm[NXT1[a]][NXT2[b]], cm[NXT2[a]][NXT1[b]]);
			pcc_nx[k][1] = r.v;
			sat4_nx = sat4_nx | r.sat;
		end
		tr_nx = c_s3[0];
		for (int d = 1; d < DIM; d++) begin
			r = fx_add(tr_nx, c_s3[d]);
			tr_nx = r.v;
			sat4_nx = sat4_nx | r.sat;
		end
	end

	// Stage 5: J and the cofactors of C.
	always_comb begin
		fx_t r;
		sat5_nx = sat_s4;
		r = fx_add(pj_s4[0], pj_s4[1]);
		sat5_nx = sat5_nx | r.sat;
		r = fx_add(r.v, pj_s4[2]);
		sat5_nx = sat5_nx | r.sat;
		j_nx = r.v;
		for (int k = 0; k < 6; k++) begin
			r = fx_sub(pcc_s4[k][0], pcc_s4[k][1]);
			cc_nx[k] = r.v;
			sat5_nx = sat5_nx | r.sat;
		end
	end

	// Stages 6 and 7: det C and the trace half of the energy.
	assign detc_nx = fx_mul(j_s5, j_s5);
	assign etr_nx  = fx_sub(tr_s5, DIM_FX);
	assign eh_nx   = fx_mul(32'(FX_HALF), etr_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1   <= f_nx;
			sat_s1 <= sat1_nx;
			pc_s2  <= pc_nx;
			pf_s2  <= pf_nx;
			sat_s2 <= sat2_nx;
			for (int j = 0; j < 3; j++) begin
				f0_s2[j] <= f_s1[0][j];
			end
			c_s3    <= c_nx;
			cf_s3   <= cf_nx;
			f0_s3   <= f0_s2;
			sat_s3  <= sat3_nx;
			pj_s4   <= pj_nx;
			pcc_s4  <= pcc_nx;
			tr_s4   <= tr_nx;
			sat_s4  <= sat4_nx;
			j_s5    <= j_nx;
			cc_s5   <= cc_nx;
			tr_s5   <= tr_s4;
			sat_s5  <= sat5_nx;
			detc_s6 <= detc_nx.v;
			etr_s6  <= etr_nx.v;
			cc_s6   <= cc_s5;
			jpos_s6 <= (j_s5 > 32'sd0);
			sat_s6  <= sat_s5 | detc_nx.sat | etr_nx.sat;
			eh_dly_q[0] <= eh_nx.v;
			for (int n = 1; n < EH_LEN; n++) begin
				eh_dly_q[n] <= eh_dly_q[n-1];
			end
			tag_dly_q[0] <= '{jpos: jpos_s6, sat: sat_s6 | eh_nx.sat};
			for (int n = 1; n < TAG_LEN; n++) begin
				tag_dly_q[n] <= tag_dly_q[n-1];
			end
		end
	end

	nhse_ln u_ln (
		.clk (clk),
		.en  (adv),
		.jac (j_s5),
		.lnj (lnj)
	);

	for (genvar k = 0; k < 6; k++) begin : g_div
		nhse_div u_div (
			.clk (clk),
			.en  (adv),
			.num (cc_s6[k]),
			.den (detc_s6),
			.quo (ci[k])
		);
	end

	// Stages 34 to 37: stress coefficient and energy once ln J is known.
	assign mlam_nx = fx_mul(lam, lnj);
	assign lsq_nx  = fx_mul(lnj, lnj);
	assign d2_nx   = fx_sub(eh_dly_q[EH_LEN-1], lnj);
	assign coef_nx = fx_sub(mlam_s34, mu);
	assign e1a_nx  = fx_mul(lam, lsq_s34);
	assign e2_nx   = fx_mul(mu, d2_s34);
	assign e1_nx   = fx_mul(32'(FX_HALF), e1a_s35);
	assign en_nx   = fx_add(e1_s36, e2_s36);

	always_ff @(posedge clk) begin
		if (adv) begin
			mlam_s34 <= mlam_nx.v;
			lsq_s34  <= lsq_nx.v;
			d2_s34   <= d2_nx.v;
			sat_s34  <= mlam_nx.sat | lsq_nx.sat | d2_nx.sat;
			coef_s35 <= coef_nx.v;
			e1a_s35  <= e1a_nx.v;
			e2_s35   <= e2_nx.v;
			sat_s35  <= sat_s34 | coef_nx.sat | e1a_nx.sat | e2_nx.sat;
			coef_s36 <= coef_s35;
			e1_s36   <= e1_nx.v;
			e2_s36   <= e2_s35;
			sat_s36  <= sat_s35 | e1_nx.sat;
			ce_dly_q[0] <= '{coef: coef_s36, energy: en_nx.v, sat: sat_s36 | en_nx.sat};
			for (int n = 1; n < CE_LEN; n++) begin
				ce_dly_q[n] <= ce_dly_q[n-1];
			end
		end
	end

	// Stage 57: scale the inverse of C by the coefficient.
	always_comb begin
		fx_t r;
		sat57_nx = tag_dly_q[TAG_LEN-1].sat | ce_dly_q[CE_LEN-1].sat;
		for (int k = 0; k < 6; k++) begin
			r = fx_mul(ce_dly_q[CE_LEN-1].coef, ci[k].v);
			ps_nx[k] = r.v;
			// Every inverse entry counts; only stress entries inside DIM do.
			sat57_nx = sat57_nx | ci[k].sat;
			if (SYM_I[k] < DIM && SYM_J[k] < DIM) begin
				sat57_nx = sat57_nx | r.sat;
			end
		end
	end

	// Stage 58: add mu on the diagonal and settle the status.
	always_comb begin
		fx_t  r;
		logic sat;
		sat = sat_s57;
		for (int k = 0; k < 6; k++) begin
			if (SYM_I[k] < DIM && SYM_J[k] < DIM) begin
				r = fx_add((SYM_I[k] == SYM_J[k]) ? mu : 32'sd0, ps_s57[k]);
				out_nx[k] = r.v;
				sat = sat | r.sat;
			end else begin
				out_nx[k] = 32'sd0;
			end
		end
		out_nx[6] = en_s57;
		st_nx = sat ? ST_SAT : ST_OK;
		if (!jpos_s57) begin
			for (int k = 0; k < 7; k++) begin
				out_nx[k] = 32'sd0;
			end
			st_nx = ST_NONPOS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ps_s57   <= ps_nx;
			en_s57   <= ce_dly_q[CE_LEN-1].energy;
			jpos_s57 <= tag_dly_q[TAG_LEN-1].jpos;
			sat_s57  <= sat57_nx;
			out_s58  <= out_nx;
			st_s58   <= st_nx;
		end
	end

	assign m_tvalid = vld_q[S_OUT];
	assign m_tuser  = st_s58;
	always_comb begin
		for (int k = 0; k < 7; k++) begin
			m_tdata[k*32 +: 32] = out_s58[k];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/nhse_div.sv */
// Pipelined rounding divider of a Q16.16 word by a positive Q16.16 word, one quotient bit a stage.
`default_nettype none

module nhse_div import nhse_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] num,
	input  wire logic signed [31:0] den,
	output fx_t                     quo
);

	typedef struct packed {
		logic [30:0]          rem;
		logic [DIV_QBITS-1:0] w;
		logic [30:0]          dvs;
		logic                 neg;
		logic                 zd;
		logic                 nz;
	} dstg_t;

	dstg_t prep_q;
	dstg_t iter_q [DIV_QBITS];
	dstg_t prep_nx;
	dstg_t iter_nx [DIV_QBITS];
	fx_t   quo_q;
	fx_t   quo_nx;

	always_comb begin
		logic [31:0] an;
		an = num[31] ? 32'(-num) : 32'(num);
		prep_nx.rem = '0;
		// Adding half the divisor before the divide gives round half away from zero.
		prep_nx.w   = {an, 16'b0} + DIV_QBITS'(den[30:1]);
		prep_nx.dvs = den[30:0];
		prep_nx.neg = num[31];
		prep_nx.zd  = den[31] | (den == 32'sd0);
		prep_nx.nz  = (num != 32'sd0);
	end

	always_comb begin
		dstg_t       src;
		logic [31:0] trial;
		logic        ge;
		for (int s = 0; s < DIV_QBITS; s++) begin
			src = (s == 0) ? prep_q : iter_q[s-1];
			trial = {src.rem, src.w[DIV_QBITS-1]};
			ge = trial >= {1'b0, src.dvs};
			iter_nx[s] = src;
			iter_nx[s].rem = ge ? 31'(trial - {1'b0, src.dvs}) : trial[30:0];
			iter_nx[s].w = {src.w[DIV_QBITS-2:0], ge};
		end
	end

	always_comb begin
		dstg_t fin;
		fin = iter_q[DIV_QBITS-1];
		quo_nx.sat = 1'b0;
		if (fin.zd) begin
			quo_nx.v = fin.nz ? (fin.neg ? FX_MIN : FX_MAX) : 32'sd0;
			quo_nx.sat = fin.nz;
		end else if (!fin.neg) begin
			if (fin.w > DIV_QBITS'(32'h7fffffff)) begin
				quo_nx.v = FX_MAX;
				quo_nx.sat = 1'b1;
			end else begin
				quo_nx.v = fin.w[31:0];
			end
		end else begin
			if (fin.w > DIV_QBITS'(32'h80000000)) begin
				quo_nx.v = FX_MIN;
				quo_nx.sat = 1'b1;
			end else begin
				quo_nx.v = 32'(-fin.w[31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_q <= prep_nx;
			for (int s = 0; s < DIV_QBITS; s++) begin
				iter_q[s] <= iter_nx[s];
			end
			quo_q <= quo_nx;
		end
	end

	assign quo = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/nhse_ln.sv */
// Pipelined natural logarithm of a positive Q16.16 word by repeated squaring of the mantissa.
`default_nettype none

module nhse_ln import nhse_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] jac,
	output logic signed [31:0]      lnj
);

	logic [30:0]          u_a;
	logic [4:0]           k_a;
	logic [30:0]          m_b;
	logic [4:0]           k_b;
	logic [30:0]          m_q  [LOG_BITS];
	logic [LOG_BITS-1:0]  fr_q [LOG_BITS];
	logic [4:0]           k_q  [LOG_BITS];
	logic [30:0]          m_nx [LOG_BITS];
	logic [LOG_BITS-1:0]  fr_nx [LOG_BITS];
	logic signed [63:0]   prod_q;
	logic signed [31:0]   lnj_q;
	logic [4:0]           k_nx;
	logic signed [29:0]   whole;

	always_comb begin
		k_nx = '0;
		for (int b = 1; b < 31; b++) begin
			if (jac[b]) k_nx = 5'(b);
		end
	end

	always_comb begin
		logic [30:0]         m;
		logic [LOG_BITS-1:0] fr;
		logic [61:0]         sq;
		logic [31:0]         t;
		for (int s = 0; s < LOG_BITS; s++) begin
			m  = (s == 0) ? m_b : m_q[s-1];
			fr = (s == 0) ? '0 : fr_q[s-1];
			sq = {31'b0, m} * {31'b0, m};
			t  = sq[61:30];
			// A square at or above two halves the mantissa and yields a one bit.
			if (t[31]) begin
				m_nx[s]  = t[31:1];
				fr_nx[s] = {fr[LOG_BITS-2:0], 1'b1};
			end else begin
				m_nx[s]  = t[30:0];
				fr_nx[s] = {fr[LOG_BITS-2:0], 1'b0};
			end
		end
	end

	assign whole = {6'({1'b0, k_q[LOG_BITS-1]} - 6'd16), fr_q[LOG_BITS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			u_a <= jac[30:0];
			k_a <= k_nx;
			m_b <= u_a << (5'd30 - k_a);
			k_b <= k_a;
			for (int s = 0; s < LOG_BITS; s++) begin
				m_q[s]  <= m_nx[s];
				fr_q[s] <= fr_nx[s];
				k_q[s]  <= (s == 0) ? k_b : k_q[s-1];
			end
			prod_q <= whole * $signed({1'b0, LN2_Q32});
			lnj_q  <= 32'((prod_q + 64'sd549755813888) >>> 40);
		end
	end

	assign lnj = lnj_q;

endmodule

`default_nettype wire
